// File: rtl/core/tmb_pkg.sv
// ============================================================================
// tmb_pkg
// Shared types and constants of the temperature Morse beeper.
// ============================================================================
package tmb_pkg;

   localparam int TempWidth = 12;
   localparam int DurWidth  = 16;
   localparam int CsrIdxWidth = 2;

   // Register reset values in milliseconds.
   localparam logic [DurWidth-1:0] DOT_MS_RESET        = 16'd325;
   localparam logic [DurWidth-1:0] DASH_MS_RESET       = 16'd725;
   localparam logic [DurWidth-1:0] SYMBOL_GAP_MS_RESET = 16'd55;
   localparam logic [DurWidth-1:0] DIGIT_GAP_MS_RESET  = 16'd100;

   // Register indexes on the configuration port.
   localparam logic [CsrIdxWidth-1:0] CSR_DOT_MS        = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DASH_MS       = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SYMBOL_GAP_MS = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_DIGIT_GAP_MS  = 2'd3;

   // Largest reported magnitude in whole degrees.
   localparam logic [6:0] MAX_DEGREES = 7'd99;

   // Index of the final symbol in the minus sign and in a digit.
   localparam logic [2:0] MINUS_LAST_SYM = 3'd5;
   localparam logic [2:0] DIGIT_LAST_SYM = 3'd4;

   // Part of the run that is being sent.
   typedef enum logic [1:0] {
      PH_MINUS = 2'd0,
      PH_TENS  = 2'd1,
      PH_GAP   = 2'd2,
      PH_UNITS = 2'd3
   } phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;  // register a new reading
      logic       split;    // split the degrees into tens and units
      logic       emit;     // load the output register with one segment
      phase_type  phase;
      logic [2:0] sym;      // symbol index within the sign or digit
      logic       half;     // 0: tone part, 1: symbol-gap part
      logic       last;     // final segment of the run
   } tmb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic neg;       // reading is negative
      logic has_tens;  // magnitude is 10 degrees or more
      logic out_free;  // output register can take a segment this cycle
   } tmb_sts_type;

endpackage

// File: rtl/core/temperature_morse_beeper.sv
// ============================================================================
// temperature_morse_beeper
// Spells a temperature reading in Morse code as a run of buzzer segments.
// ============================================================================
// Each input word carries one temperature in sixteenths of a degree Celsius.
// The block truncates its magnitude to whole degrees, saturates it at 99, and
// sends a run of output words, each one buzzer segment: a tone flag and a
// length in milliseconds. A negative reading opens with the minus sign (dash,
// four dots, dash); the tens digit follows only for magnitudes of ten or more;
// then comes one digit-gap silence and the units digit. Every dot or dash is
// a tone word followed by a symbol-gap silence word, and the final word of a
// run has tlast set. A run is 11 to 33 words long. After a reading is taken,
// the controller splits the degrees into digits and then issues one segment
// per cycle into the output register while that register is free; a stalled
// sink holds back the next segment until the waiting word is taken.
// The next reading is accepted as soon as the last segment of the previous
// run is in the output register, even while that word still waits. The four
// timing registers are written through the csr port; the user must write
// them only while no run is active, as the block does not enforce this.
module temperature_morse_beeper
   import tmb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // [11:0] temperature_sixteenths, [15:12] zero

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DurWidth-1:0]    rsp_tdata,   // [15:0] duration_ms
   output logic                   rsp_tuser,   // [0] tone_on
   output logic                   rsp_tlast,   // last_segment

   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_addr,
   input  logic [DurWidth-1:0]    csr_wdata
);

   tmb_cmd_type cmd;
   tmb_sts_type sts;

   // The sequencer decides which segment comes next and when.
   tmb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the reading, its digits, the timing registers and
   // the output register that decouples the sink.
   tmb_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .temperature_sixteenths (req_tdata[TempWidth-1:0]),
      .csr_we                 (csr_we),
      .csr_addr               (csr_addr),
      .csr_wdata              (csr_wdata),
      .cmd                    (cmd),
      .sts                    (sts),
      .rsp_tvalid             (rsp_tvalid),
      .rsp_tready             (rsp_tready),
      .rsp_tdata              (rsp_tdata),
      .rsp_tuser              (rsp_tuser),
      .rsp_tlast              (rsp_tlast)
   );

endmodule

// File: rtl/core/tmb_ctrl.sv
// ============================================================================
// tmb_ctrl
// Sequencer that walks through the sign, digits, gaps and symbols of a run.
// ============================================================================
module tmb_ctrl
   import tmb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  tmb_sts_type sts,
   output tmb_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SPLIT = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [2:0] sym_ff, sym_in;
   logic       half_ff, half_in;

   logic       emit;
   logic       last;
   logic [2:0] end_sym;

   assign end_sym = (phase_ff == PH_MINUS) ? MINUS_LAST_SYM : DIGIT_LAST_SYM;
   assign emit    = (state_ff == ST_SEND) && sts.out_free;
   assign last    = (phase_ff == PH_UNITS) && (sym_ff == DIGIT_LAST_SYM) && half_ff;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_tvalid;
      cmd.split   = (state_ff == ST_SPLIT);
      cmd.emit    = emit;
      cmd.phase   = phase_ff;
      cmd.sym     = sym_ff;
      cmd.half    = half_ff;
      cmd.last    = last;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      sym_in   = sym_ff;
      half_in  = half_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            state_in = ST_SEND;
            sym_in   = 3'd0;
            half_in  = 1'b0;
            if (sts.neg) begin
               phase_in = PH_MINUS;
            end else if (sts.has_tens) begin
               phase_in = PH_TENS;
            end else begin
               phase_in = PH_GAP;
            end
         end
         ST_SEND: begin
            if (emit) begin
               if (phase_ff == PH_GAP) begin
                  phase_in = PH_UNITS;
                  sym_in   = 3'd0;
                  half_in  = 1'b0;
               end else if (!half_ff) begin
                  half_in = 1'b1;
               end else begin
                  half_in = 1'b0;
                  if (sym_ff == end_sym) begin
                     sym_in = 3'd0;
                     case (phase_ff)
                        PH_MINUS: phase_in = sts.has_tens ? PH_TENS : PH_GAP;
                        PH_TENS:  phase_in = PH_GAP;
                        default:  state_in = ST_IDLE;
                     endcase
                  end else begin
                     sym_in = sym_ff + 3'd1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_MINUS;
         sym_ff   <= 3'd0;
         half_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         sym_ff   <= sym_in;
         half_ff  <= half_in;
      end
   end

   // A segment is only issued when the output register can hold it.
   assert property (@(posedge clock) disable iff (reset) cmd.emit |-> sts.out_free)
      else $error("segment issued while output register is full");

   // The run ends after its final segment, a units-digit symbol gap.
   assert property (@(posedge clock) disable iff (reset)
      cmd.last && cmd.emit |=> state_ff == ST_IDLE)
      else $error("run did not end after its final segment");

   // The symbol index never runs past the end of the minus sign.
   assert property (@(posedge clock) disable iff (reset) sym_ff <= MINUS_LAST_SYM)
      else $error("symbol index out of range");

   // The digit split always directly follows the capture of a reading.
   assert property (@(posedge clock) disable iff (reset) cmd.capture |=> cmd.split)
      else $error("split did not follow capture");

endmodule

// File: rtl/core/tmb_datapath.sv
// ============================================================================
// tmb_datapath
// Reading capture, digit split, timing registers and the output register.
// ============================================================================
module tmb_datapath
   import tmb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [TempWidth-1:0]   temperature_sixteenths,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_addr,
   input  logic [DurWidth-1:0]    csr_wdata,
   input  tmb_cmd_type            cmd,
   output tmb_sts_type            sts,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DurWidth-1:0]    rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   logic [DurWidth-1:0] dot_ms_ff, dash_ms_ff, sym_gap_ms_ff, digit_gap_ms_ff;

   logic       neg_ff;
   logic [6:0] deg_ff;
   logic [3:0] tens_ff, units_ff;

   logic                valid_ff;
   logic [DurWidth-1:0] dur_ff;
   logic                tone_ff, last_ff;

   logic [12:0] mag16;
   logic [8:0]  deg_full;
   logic [6:0]  deg_sat;
   logic [14:0] prod;
   logic [3:0]  tens;
   logic [6:0]  tens_x10;
   logic [6:0]  units_wide;

   logic [3:0]          digit;
   logic                is_dot;
   logic                is_dash;
   logic                seg_tone;
   logic [DurWidth-1:0] seg_dur;

   // Magnitude in sixteenths, truncated to whole degrees and saturated.
   always_comb begin
      if (temperature_sixteenths[TempWidth-1]) begin
         mag16 = 13'd4096 - {1'b0, temperature_sixteenths};
      end else begin
         mag16 = {1'b0, temperature_sixteenths};
      end
      deg_full = mag16[12:4];
      deg_sat  = (deg_full > {2'b00, MAX_DEGREES}) ? MAX_DEGREES : deg_full[6:0];
   end

   // Divide by ten through the reciprocal 205/2048, exact below 1029.
   always_comb begin
      prod       = {8'd0, deg_ff} * 15'd205;
      tens       = prod[14:11];
      tens_x10   = {tens, 3'b000} + {2'b00, tens, 1'b0};
      units_wide = deg_ff - tens_x10;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         neg_ff <= temperature_sixteenths[TempWidth-1];
         deg_ff <= deg_sat;
      end
      if (cmd.split) begin
         tens_ff  <= tens;
         units_ff <= units_wide[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ms_ff       <= DOT_MS_RESET;
         dash_ms_ff      <= DASH_MS_RESET;
         sym_gap_ms_ff   <= SYMBOL_GAP_MS_RESET;
         digit_gap_ms_ff <= DIGIT_GAP_MS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DOT_MS:        dot_ms_ff       <= csr_wdata;
            CSR_DASH_MS:       dash_ms_ff      <= csr_wdata;
            CSR_SYMBOL_GAP_MS: sym_gap_ms_ff   <= csr_wdata;
            CSR_DIGIT_GAP_MS:  digit_gap_ms_ff <= csr_wdata;
            default:           ;
         endcase
      end
   end

   // Digits one to five open with dots, six to nine with dashes, zero is all dashes.
   always_comb begin
      digit = (cmd.phase == PH_TENS) ? tens_ff : units_ff;
      if (digit <= 4'd5) begin
         is_dot = ({1'b0, cmd.sym} < digit);
      end else begin
         is_dot = ({1'b0, cmd.sym} >= (digit - 4'd5));
      end
      if (cmd.phase == PH_MINUS) begin
         is_dash = (cmd.sym == 3'd0) || (cmd.sym == MINUS_LAST_SYM);
      end else begin
         is_dash = !is_dot;
      end
      if (cmd.phase == PH_GAP) begin
         seg_tone = 1'b0;
         seg_dur  = digit_gap_ms_ff;
      end else if (cmd.half) begin
         seg_tone = 1'b0;
         seg_dur  = sym_gap_ms_ff;
      end else begin
         seg_tone = 1'b1;
         seg_dur  = is_dash ? dash_ms_ff : dot_ms_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         dur_ff  <= seg_dur;
         tone_ff <= seg_tone;
         last_ff <= cmd.last;
      end
   end

   always_comb begin
      sts.neg      = neg_ff;
      sts.has_tens = (deg_ff >= 7'd10);
      sts.out_free = !valid_ff || rsp_tready;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = dur_ff;
   assign rsp_tuser  = tone_ff;
   assign rsp_tlast  = last_ff;

   // Both digits fit in one decimal place after the split.
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.split) |-> (tens_ff <= 4'd9) && (units_ff <= 4'd9))
      else $error("digit split out of range");

   // The final segment of a run is always a silence.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser)
      else $error("final segment carries a tone");

endmodule
